@@ rtl/core/kitt_pkg.sv @@
`timescale 1ns / 1ps

package kitt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int KEY_BITS    = 12;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int OP_W    = 2;
  localparam int KIND_W  = 3;
  localparam int KEY_W   = 12;
  localparam int TIME_W  = 24;
  localparam int DELTA_W = 16;

  localparam logic [KEY_W-1:0]  KEY_MASK    = KEY_W'((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [TIME_W-1:0] ELAPSED_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STARTED = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_STOPPED = 3'd2,
    KIND_MISSING = 3'd3,
    KIND_FIRED   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] elapsed;
    logic              rep;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_ACT,
    ST_TAIL_RD,
    ST_TAIL_WR,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_TICK_FLUSH,
    ST_DUE_RD,
    ST_DUE_KEY
  } state_t;

endpackage

@@ rtl/core/keyed_interval_timer_table.sv @@
`timescale 1ns / 1ps

// Keyed interval timer table. Up to TABLE_DEPTH timers live in one entry
// memory (key, period, elapsed, repeat flag) with a registered read; a
// second small memory queues the keys that fire on a tick. Every access to
// the entry memory is a read, then a compare or write back. A start or stop
// scans the entries for its key; a stop of a found key adds a move of the
// tail entry into the freed slot. A tick reads and updates every live
// entry, and then, for each fired timer in firing order, searches for its
// key and rearms or removes it. Fired results leave in table order with
// last set on the final one; a start or stop gives exactly one result. The
// output register lets a new beat enter while the previous result waits to
// be taken.
module keyed_interval_timer_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kitt_pkg::OP_W-1:0]     in_operation,
  input  logic [kitt_pkg::KEY_W-1:0]    in_key,
  input  logic [kitt_pkg::TIME_W-1:0]   in_period,
  input  logic                          in_repeating,
  input  logic [kitt_pkg::DELTA_W-1:0]  in_delta,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kitt_pkg::KIND_W-1:0]   out_kind,
  output logic [kitt_pkg::KEY_W-1:0]    out_fired_key,
  output logic [kitt_pkg::TIME_W-1:0]   out_fired_elapsed,
  output logic                          out_last
);
  import kitt_pkg::*;

  // Storage
  entry_t           entry_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] due_mem   [TABLE_DEPTH];
  entry_t           ent_rd_r;
  logic [KEY_W-1:0] due_rd_r;

  // Control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ndue_r, ndue_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  jdx_r, jdx_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              found_r, found_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Beat and result payload
  op_t               op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0] period_r, period_nxt;
  logic              rep_r, rep_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic [KEY_W-1:0]  pend_key_r, pend_key_nxt;
  logic [TIME_W-1:0] pend_el_r, pend_el_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [TIME_W-1:0] out_el_r, out_el_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory ports
  logic              ent_re, ent_we;
  logic [IDX_W-1:0]  ent_raddr, ent_waddr;
  entry_t            ent_wdata;
  logic              due_re, due_we;
  logic [IDX_W-1:0]  due_raddr, due_waddr;
  logic [KEY_W-1:0]  due_wdata;

  // Derived values
  logic              out_free;
  logic [CNT_W-1:0]  count_m1;
  logic [CNT_W-1:0]  ndue_m1;
  logic [IDX_W-1:0]  tail_idx;
  logic              scan_end;
  logic              due_end;
  logic              table_full;
  logic [TIME_W:0]   el_sum;
  logic [TIME_W-1:0] el_sat;
  logic              is_due;

  assign out_free   = !out_valid_r || out_ready;
  assign count_m1   = count_r - 1'b1;
  assign ndue_m1    = ndue_r - 1'b1;
  assign tail_idx   = count_m1[IDX_W-1:0];
  assign scan_end   = (idx_r == tail_idx);
  assign due_end    = (jdx_r == ndue_m1[IDX_W-1:0]);
  assign table_full = (count_r == CNT_W'(TABLE_DEPTH));
  assign el_sum     = {1'b0, ent_rd_r.elapsed} + (TIME_W + 1)'(delta_r);
  assign el_sat     = el_sum[TIME_W] ? ELAPSED_MAX : el_sum[TIME_W-1:0];
  assign is_due     = (el_sat >= ent_rd_r.period);

  // Next state, memory controls and result loading
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ndue_nxt      = ndue_r;
    idx_nxt       = idx_r;
    jdx_nxt       = jdx_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    pend_v_nxt    = pend_v_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    period_nxt    = period_r;
    rep_nxt       = rep_r;
    delta_nxt     = delta_r;
    pend_key_nxt  = pend_key_r;
    pend_el_nxt   = pend_el_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_key_nxt   = out_key_r;
    out_el_nxt    = out_el_r;
    out_last_nxt  = out_last_r;
    ent_re        = 1'b0;
    ent_raddr     = idx_r;
    ent_we        = 1'b0;
    ent_waddr     = pos_r;
    ent_wdata     = ent_rd_r;
    due_re        = 1'b0;
    due_raddr     = jdx_r;
    due_we        = 1'b0;
    due_waddr     = ndue_r[IDX_W-1:0];
    due_wdata     = ent_rd_r.key;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = op_t'(in_operation);
          key_nxt    = in_key & KEY_MASK;
          period_nxt = in_period;
          rep_nxt    = in_repeating;
          delta_nxt  = in_delta;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          ndue_nxt   = '0;
          pend_v_nxt = 1'b0;
          unique case (in_operation)
            OP_START, OP_STOP: begin
              state_nxt = (count_r == '0) ? ST_ACT : ST_FIND_RD;
            end
            OP_TICK: begin
              state_nxt = (count_r == '0) ? ST_IDLE : ST_TICK_RD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // Walk the table for key_r
      ST_FIND_RD: begin
        ent_re    = 1'b1;
        ent_raddr = idx_r;
        state_nxt = ST_FIND_CMP;
      end

      ST_FIND_CMP: begin
        if (ent_rd_r.key == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
          state_nxt = ST_ACT;
        end else if (scan_end) begin
          found_nxt = 1'b0;
          state_nxt = ST_ACT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_FIND_RD;
        end
      end

      // Act on the search outcome
      ST_ACT: begin
        unique case (op_r)
          OP_START: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_key_nxt   = key_r;
              out_el_nxt    = '0;
              out_last_nxt  = 1'b1;
              ent_wdata     = '{key: key_r, period: period_r, elapsed: '0, rep: rep_r};
              if (found_r) begin
                ent_we       = 1'b1;
                ent_waddr    = pos_r;
                out_kind_nxt = KIND_STARTED;
              end else if (table_full) begin
                out_kind_nxt = KIND_FULL;
              end else begin
                ent_we       = 1'b1;
                ent_waddr    = count_r[IDX_W-1:0];
                count_nxt    = count_r + 1'b1;
                out_kind_nxt = KIND_STARTED;
              end
              state_nxt = ST_IDLE;
            end
          end
          OP_STOP: begin
            if (found_r) begin
              state_nxt = ST_TAIL_RD;
            end else if (out_free) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_MISSING;
              out_key_nxt   = key_r;
              out_el_nxt    = '0;
              out_last_nxt  = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          default: begin
            // Post-tick pass: rearm or remove the fired timer
            if (found_r && !ent_rd_r.rep) begin
              state_nxt = ST_TAIL_RD;
            end else begin
              if (found_r) begin
                ent_we            = 1'b1;
                ent_waddr         = pos_r;
                ent_wdata.elapsed = '0;
              end
              jdx_nxt   = jdx_r + 1'b1;
              state_nxt = due_end ? ST_IDLE : ST_DUE_RD;
            end
          end
        endcase
      end

      // Move the tail entry into the freed slot
      ST_TAIL_RD: begin
        ent_re    = 1'b1;
        ent_raddr = tail_idx;
        state_nxt = ST_TAIL_WR;
      end

      ST_TAIL_WR: begin
        if (op_r == OP_STOP) begin
          if (out_free) begin
            ent_we        = 1'b1;
            ent_waddr     = pos_r;
            count_nxt     = count_m1;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_STOPPED;
            out_key_nxt   = key_r;
            out_el_nxt    = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          ent_we    = 1'b1;
          ent_waddr = pos_r;
          count_nxt = count_m1;
          jdx_nxt   = jdx_r + 1'b1;
          state_nxt = due_end ? ST_IDLE : ST_DUE_RD;
        end
      end

      // Advance every elapsed time, queue due keys
      ST_TICK_RD: begin
        ent_re    = 1'b1;
        ent_raddr = idx_r;
        state_nxt = ST_TICK_EV;
      end

      ST_TICK_EV: begin
        if (!(is_due && pend_v_r && !out_free)) begin
          ent_we            = 1'b1;
          ent_waddr         = idx_r;
          ent_wdata.elapsed = el_sat;
          if (is_due) begin
            due_we       = 1'b1;
            due_waddr    = ndue_r[IDX_W-1:0];
            due_wdata    = ent_rd_r.key;
            ndue_nxt     = ndue_r + 1'b1;
            pend_v_nxt   = 1'b1;
            pend_key_nxt = ent_rd_r.key;
            pend_el_nxt  = el_sat;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_FIRED;
              out_key_nxt   = pend_key_r;
              out_el_nxt    = pend_el_r;
              out_last_nxt  = 1'b0;
            end
          end
          if (scan_end) begin
            state_nxt = ST_TICK_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_TICK_RD;
          end
        end
      end

      // Release the final fired result with last set
      ST_TICK_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRED;
          out_key_nxt   = pend_key_r;
          out_el_nxt    = pend_el_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          jdx_nxt       = '0;
          state_nxt     = ST_DUE_RD;
        end
      end

      // Fetch the next fired key in firing order
      ST_DUE_RD: begin
        due_re    = 1'b1;
        due_raddr = jdx_r;
        state_nxt = ST_DUE_KEY;
      end

      ST_DUE_KEY: begin
        key_nxt   = due_rd_r;
        idx_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = ST_FIND_RD;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Entry and due-key memories
  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_r <= entry_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[due_waddr] <= due_wdata;
    end
    if (due_re) begin
      due_rd_r <= due_mem[due_raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    ndue_r     <= ndue_nxt;
    idx_r      <= idx_nxt;
    jdx_r      <= jdx_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    period_r   <= period_nxt;
    rep_r      <= rep_nxt;
    delta_r    <= delta_nxt;
    pend_key_r <= pend_key_nxt;
    pend_el_r  <= pend_el_nxt;
    out_kind_r <= out_kind_nxt;
    out_key_r  <= out_key_nxt;
    out_el_r   <= out_el_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_fired_key     = out_key_r;
  assign out_fired_elapsed = out_el_r;
  assign out_last          = out_last_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
              count_r + 1'b1 == $past(count_r)))
    else $error("entry count moved by more than one");

  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ent_we && ent_re))
    else $error("entry memory read and written in one cycle");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_FIRED) |-> out_last_r)
    else $error("start or stop result without last");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("fired result left pending at idle");

endmodule
